FILE: rtl/core/fmbs_pkg.sv
// Shared types, constants and helper functions for the FM-index backward search block.
// Used by every other file of the block; depends on nothing.
package fmbs_pkg;

    localparam int TEXT_DEPTH  = 65536;
    localparam int CKPT_DEPTH  = 4096;
    localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
    localparam int CKPT_AW     = $clog2(CKPT_DEPTH);
    localparam int CNT_W       = 17;
    localparam int RATIO_W     = 9;
    localparam int SYM_W       = 3;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_BASES   = 4;

    localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(16);
    localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(256);
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(32);

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATIO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_A      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_C      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_G      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_T      = 3'd4;

    localparam logic [SYM_W-1:0] SYM_LAST_BASE = 3'd3;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [NUM_BASES-1:0][CNT_W-1:0] ckpt_word_t;

    typedef struct packed {
        logic                   bwt_we;
        logic [TEXT_AW-1:0]     bwt_waddr;
        logic [SYM_W-1:0]       bwt_wdata;
        logic [TEXT_AW-1:0]     bwt_raddr;
        logic                   ckpt_we;
        logic [CKPT_AW-1:0]     ckpt_waddr;
        ckpt_word_t             ckpt_wdata;
        logic [CKPT_AW-1:0]     ckpt_raddr;
    } store_req_t;

    function automatic count_t sat_count(input logic [CNT_W+1:0] v);
        count_t r;
        if (v[CNT_W+1:CNT_W] != 2'b00)
        begin
            r = '1;
        end
        else
        begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/fmbs_in_if.sv
// Input channel of the FM-index backward search block: valid, ready and one item.
// Depends on fmbs_pkg for the field widths.
interface fmbs_in_if;
    logic                         valid;
    logic                         ready;
    logic [fmbs_pkg::OP_W-1:0]    opcode;
    logic [fmbs_pkg::SYM_W-1:0]   symbol;
    fmbs_pkg::count_t             start_low;
    fmbs_pkg::count_t             start_high;
    logic                         last_base;

    modport source (output valid, opcode, symbol, start_low, start_high, last_base,
                    input ready);
    modport sink (input valid, opcode, symbol, start_low, start_high, last_base,
                  output ready);
endinterface

FILE: rtl/core/fmbs_out_if.sv
// Output channel of the FM-index backward search block: valid, ready and one result.
// Depends on fmbs_pkg for the field widths.
interface fmbs_out_if;
    logic             valid;
    logic             ready;
    fmbs_pkg::count_t low_bound;
    fmbs_pkg::count_t high_bound;
    fmbs_pkg::count_t match_count;
    logic             is_empty;
    logic             last;

    modport source (output valid, low_bound, high_bound, match_count, is_empty, last,
                    input ready);
    modport sink (input valid, low_bound, high_bound, match_count, is_empty, last,
                  output ready);
endinterface

FILE: rtl/core/fm_index_backward_search.sv
// FM-index backward search over a DNA BWT. For a query base, with R the sample ratio, each
// bound needs a division by R and a scan of up to R stored symbols through the single read port.
// One item is in work at a time; a result waits in the output register while the next is taken.
// Reset clears control state, counts and search bounds; the stores are undefined until written.
module fm_index_backward_search (
    input  logic                                clk,
    input  logic                                rst_n,
    fmbs_in_if.sink                             in_ch,
    fmbs_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [fmbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fmbs_pkg::CNT_W-1:0]          cfg_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LDIV  = 4'd1;
    localparam logic [3:0] S_QSEL  = 4'd2;
    localparam logic [3:0] S_QDIV  = 4'd3;
    localparam logic [3:0] S_QMUL  = 4'd4;
    localparam logic [3:0] S_QCK   = 4'd5;
    localparam logic [3:0] S_QSCAN = 4'd6;
    localparam logic [3:0] S_QDRN  = 4'd7;
    localparam logic [3:0] S_QREC  = 4'd8;
    localparam logic [3:0] S_QUPD  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    localparam int AW = fmbs_pkg::TEXT_AW;
    localparam int KW = fmbs_pkg::CKPT_AW;
    localparam int SW = fmbs_pkg::SYM_W;
    localparam int CW = fmbs_pkg::CNT_W;

    logic [3:0]                    state_reg, state_next;
    logic [fmbs_pkg::RATIO_W-1:0]  ratio_reg, ratio_next;
    fmbs_pkg::ckpt_word_t          cb_reg, cb_next;
    fmbs_pkg::ckpt_word_t          run_reg, run_next;
    fmbs_pkg::count_t              load_pos_reg, load_pos_next;
    fmbs_pkg::count_t              low_reg, low_next;
    fmbs_pkg::count_t              high_reg, high_next;
    logic                          dead_reg, dead_next;
    logic [SW-1:0]                 sym_reg, sym_next;
    logic                          lastb_reg, lastb_next;
    logic                          phase_reg, phase_next;
    fmbs_pkg::count_t              loc_reg, loc_next;
    fmbs_pkg::count_t              ol_reg, ol_next;
    fmbs_pkg::count_t              occ_reg, occ_next;
    fmbs_pkg::count_t              scan_reg, scan_next;
    logic                          pend_reg, pend_next;
    logic [KW-1:0]                 ckid_reg, ckid_next;
    logic                          ov_reg, ov_next;
    fmbs_pkg::count_t              olow_reg, olow_next;
    fmbs_pkg::count_t              ohigh_reg, ohigh_next;
    fmbs_pkg::count_t              ocnt_reg, ocnt_next;
    logic                          oemp_reg, oemp_next;
    logic                          olast_reg, olast_next;

    logic [fmbs_pkg::RATIO_W-1:0]  eff_ratio;
    logic                          div_start;
    fmbs_pkg::count_t              div_dividend;
    logic                          div_done;
    fmbs_pkg::count_t              div_quot;
    logic [fmbs_pkg::RATIO_W-1:0]  div_rem;
    fmbs_pkg::store_req_t          sreq;
    logic [SW-1:0]                 bwt_rdata;
    fmbs_pkg::ckpt_word_t          ckpt_rdata;
    fmbs_pkg::count_t              loc_raw, loc_clamp;
    logic [KW+fmbs_pkg::RATIO_W-1:0] start_prod;
    logic [CW+1:0]                 sum_low, sum_high, span;
    fmbs_pkg::count_t              sat_low, sat_high;
    logic                          in_fire, scan_hit;

    fmbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_ratio),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    fmbs_store u_store (
        .clk        (clk),
        .req        (sreq),
        .bwt_rdata  (bwt_rdata),
        .ckpt_rdata (ckpt_rdata)
    );

    always_comb
    begin
        if (ratio_reg < fmbs_pkg::RATIO_MIN)
        begin
            eff_ratio = fmbs_pkg::RATIO_MIN;
        end
        else if (ratio_reg > fmbs_pkg::RATIO_MAX)
        begin
            eff_ratio = fmbs_pkg::RATIO_MAX;
        end
        else
        begin
            eff_ratio = ratio_reg;
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && (state_reg == S_IDLE);
    assign loc_raw     = phase_reg ? high_reg : low_reg - 1'b1;
    assign loc_clamp   = (loc_raw >= load_pos_reg) ? load_pos_reg - 1'b1 : loc_raw;
    assign start_prod  = ckid_reg * eff_ratio;
    assign scan_hit    = pend_reg && (bwt_rdata == sym_reg);
    assign sum_low     = {2'b00, cb_reg[sym_reg[1:0]]} + {2'b00, ol_reg} + 1'b1;
    assign sum_high    = {2'b00, cb_reg[sym_reg[1:0]]} + {2'b00, occ_reg};
    assign sat_low     = fmbs_pkg::sat_count(sum_low);
    assign sat_high    = fmbs_pkg::sat_count(sum_high);
    assign span        = {2'b00, high_reg} - {2'b00, low_reg} + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        ratio_next    = ratio_reg;
        cb_next       = cb_reg;
        run_next      = run_reg;
        load_pos_next = load_pos_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        dead_next     = dead_reg;
        sym_next      = sym_reg;
        lastb_next    = lastb_reg;
        phase_next    = phase_reg;
        loc_next      = loc_reg;
        ol_next       = ol_reg;
        occ_next      = occ_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        ckid_next     = ckid_reg;
        ov_next       = ov_reg && !out_ch.ready;
        olow_next     = olow_reg;
        ohigh_next    = ohigh_reg;
        ocnt_next     = ocnt_reg;
        oemp_next     = oemp_reg;
        olast_next    = olast_reg;
        div_start     = 1'b0;
        div_dividend  = load_pos_reg;
        sreq            = '0;
        sreq.bwt_raddr  = scan_reg[AW-1:0];
        sreq.ckpt_raddr = ckid_reg;
        sreq.bwt_waddr  = load_pos_reg[AW-1:0];
        sreq.bwt_wdata  = sym_reg;
        sreq.ckpt_waddr = div_quot[KW-1:0];
        sreq.ckpt_wdata = run_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                fmbs_pkg::REG_SAMPLE_RATIO: ratio_next = cfg_data[fmbs_pkg::RATIO_W-1:0];
                fmbs_pkg::REG_COUNT_A:      cb_next[0] = cfg_data;
                fmbs_pkg::REG_COUNT_C:      cb_next[1] = cfg_data;
                fmbs_pkg::REG_COUNT_G:      cb_next[2] = cfg_data;
                fmbs_pkg::REG_COUNT_T:      cb_next[3] = cfg_data;
                default:                    ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sym_next   = in_ch.symbol;
                    lastb_next = in_ch.last_base;
                    unique case (in_ch.opcode)
                        fmbs_pkg::OP_LOAD:
                        begin
                            if (load_pos_reg < CW'(fmbs_pkg::TEXT_DEPTH))
                            begin
                                div_start  = 1'b1;
                                state_next = S_LDIV;
                            end
                        end
                        fmbs_pkg::OP_START:
                        begin
                            low_next  = in_ch.start_low;
                            high_next = in_ch.start_high;
                            dead_next = in_ch.start_low > in_ch.start_high;
                        end
                        fmbs_pkg::OP_QUERY:
                        begin
                            phase_next = 1'b0;
                            if (dead_reg)
                            begin
                                state_next = S_FIN;
                            end
                            else if (in_ch.symbol > fmbs_pkg::SYM_LAST_BASE)
                            begin
                                dead_next  = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_QSEL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LDIV:
            begin
                if (div_done)
                begin
                    sreq.bwt_we  = 1'b1;
                    sreq.ckpt_we = (div_rem == '0) && (div_quot < CW'(fmbs_pkg::CKPT_DEPTH));
                    if (sym_reg <= fmbs_pkg::SYM_LAST_BASE)
                    begin
                        run_next[sym_reg[1:0]] =
                            fmbs_pkg::sat_count({2'b00, run_reg[sym_reg[1:0]]} + 1'b1);
                    end
                    load_pos_next = load_pos_reg + 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_QSEL:
            begin
                if ((load_pos_reg == '0) || (!phase_reg && (low_reg == '0)))
                begin
                    occ_next   = '0;
                    state_next = S_QREC;
                end
                else
                begin
                    loc_next     = loc_clamp;
                    div_dividend = loc_clamp;
                    div_start    = 1'b1;
                    state_next   = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (div_done)
                begin
                    if (div_quot >= CW'(fmbs_pkg::CKPT_DEPTH))
                    begin
                        ckid_next = KW'(fmbs_pkg::CKPT_DEPTH - 1);
                    end
                    else
                    begin
                        ckid_next = div_quot[KW-1:0];
                    end
                    state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                scan_next  = start_prod[CW-1:0];
                state_next = S_QCK;
            end
            S_QCK:
            begin
                occ_next   = ckpt_rdata[sym_reg[1:0]];
                pend_next  = 1'b0;
                state_next = S_QSCAN;
            end
            S_QSCAN:
            begin
                pend_next = 1'b1;
                if (scan_hit)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == loc_reg)
                begin
                    state_next = S_QDRN;
                end
            end
            S_QDRN:
            begin
                if (scan_hit)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                pend_next  = 1'b0;
                state_next = S_QREC;
            end
            S_QREC:
            begin
                if (!phase_reg)
                begin
                    ol_next    = occ_reg;
                    phase_next = 1'b1;
                    state_next = S_QSEL;
                end
                else
                begin
                    state_next = S_QUPD;
                end
            end
            S_QUPD:
            begin
                low_next   = sat_low;
                high_next  = sat_high;
                dead_next  = sat_low > sat_high;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    olow_next  = low_reg;
                    ohigh_next = high_reg;
                    oemp_next  = dead_reg || (low_reg > high_reg);
                    ocnt_next  = (dead_reg || (low_reg > high_reg)) ? '0 :
                                 fmbs_pkg::sat_count(span);
                    olast_next = lastb_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ratio_reg    <= fmbs_pkg::RATIO_RESET;
            cb_reg       <= '0;
            run_reg      <= '0;
            load_pos_reg <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            dead_reg     <= 1'b0;
            phase_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ratio_reg    <= ratio_next;
            cb_reg       <= cb_next;
            run_reg      <= run_next;
            load_pos_reg <= load_pos_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            dead_reg     <= dead_next;
            phase_reg    <= phase_next;
            pend_reg     <= pend_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        lastb_reg <= lastb_next;
        loc_reg   <= loc_next;
        ol_reg    <= ol_next;
        occ_reg   <= occ_next;
        scan_reg  <= scan_next;
        ckid_reg  <= ckid_next;
        olow_reg  <= olow_next;
        ohigh_reg <= ohigh_next;
        ocnt_reg  <= ocnt_next;
        oemp_reg  <= oemp_next;
        olast_reg <= olast_next;
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.low_bound   = olow_reg;
    assign out_ch.high_bound  = ohigh_reg;
    assign out_ch.match_count = ocnt_reg;
    assign out_ch.is_empty    = oemp_reg;
    assign out_ch.last        = olast_reg;
endmodule

FILE: rtl/core/fmbs_div.sv
// Restoring divider, one quotient bit per cycle, for position divided by sample ratio.
// Depends on fmbs_pkg for widths.
module fmbs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  fmbs_pkg::count_t              dividend,
    input  logic [fmbs_pkg::RATIO_W-1:0]  divisor,
    output logic                          done,
    output fmbs_pkg::count_t              quot,
    output logic [fmbs_pkg::RATIO_W-1:0]  rem
);
    localparam int CW = $clog2(fmbs_pkg::CNT_W + 1);

    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    fmbs_pkg::count_t              quot_reg, quot_next;
    logic [fmbs_pkg::RATIO_W-1:0]  rem_reg, rem_next;
    logic [fmbs_pkg::RATIO_W-1:0]  div_reg, div_next;
    logic [fmbs_pkg::RATIO_W:0]    trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quot_reg[fmbs_pkg::CNT_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next  = fmbs_pkg::RATIO_W'(trial - {1'b0, div_reg});
                quot_next = {quot_reg[fmbs_pkg::CNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[fmbs_pkg::RATIO_W-1:0];
                quot_next = {quot_reg[fmbs_pkg::CNT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(fmbs_pkg::CNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule

FILE: rtl/core/fmbs_store.sv
// Symbol store and occurrence checkpoint store, each one write and one registered read port.
// Depends on fmbs_pkg for the request struct and depths.
module fmbs_store (
    input  logic                         clk,
    input  fmbs_pkg::store_req_t         req,
    output logic [fmbs_pkg::SYM_W-1:0]   bwt_rdata,
    output fmbs_pkg::ckpt_word_t         ckpt_rdata
);
    logic [fmbs_pkg::SYM_W-1:0] bwt_mem [fmbs_pkg::TEXT_DEPTH];
    fmbs_pkg::ckpt_word_t       ckpt_mem [fmbs_pkg::CKPT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.bwt_we)
        begin
            bwt_mem[req.bwt_waddr] <= req.bwt_wdata;
        end
        bwt_rdata <= bwt_mem[req.bwt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.ckpt_we)
        begin
            ckpt_mem[req.ckpt_waddr] <= req.ckpt_wdata;
        end
        ckpt_rdata <= ckpt_mem[req.ckpt_raddr];
    end
endmodule

FILE: test/fm_index_backward_search_tb.sv
// Self-checking testbench for the FM-index backward search block over a DNA BWT.
// Directed table then random load and search traffic, each result checked against table
// or local interval predictor. Needs fmbs_pkg, fmbs_in_if, fmbs_out_if and the block.
`timescale 1ns / 1ps

module fm_index_backward_search_tb;

    localparam logic [fmbs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [fmbs_pkg::SYM_W-1:0] SYM_A = 3'd0;
    localparam logic [fmbs_pkg::SYM_W-1:0] SYM_C = 3'd1;
    localparam logic [fmbs_pkg::SYM_W-1:0] SYM_G = 3'd2;
    localparam logic [fmbs_pkg::SYM_W-1:0] SYM_T = 3'd3;
    localparam logic [fmbs_pkg::SYM_W-1:0] SYM_DOLLAR = 3'd4;
    localparam logic [fmbs_pkg::SYM_W-1:0] SYM_OTHER = 3'd7;
    localparam fmbs_pkg::count_t CNT_MAX = '1;
    localparam int SETTLE_CYCLES = 700;
    localparam int HOLD_CYCLES = 4000;
    localparam int ITEMS_PER_PHASE = 300;

    typedef struct packed {
        fmbs_pkg::count_t lo;
        fmbs_pkg::count_t hi;
        fmbs_pkg::count_t cnt;
        logic             empty;
        logic             last;
    } bounds_t;

    typedef struct packed {
        logic [fmbs_pkg::OP_W-1:0]  op;
        logic [fmbs_pkg::SYM_W-1:0] sym;
        fmbs_pkg::count_t           lo;
        fmbs_pkg::count_t           hi;
        logic                       last;
        logic                       typed;
        fmbs_pkg::count_t           e_lo;
        fmbs_pkg::count_t           e_hi;
        fmbs_pkg::count_t           e_cnt;
        logic                       e_empty;
    } row_t;

    localparam int NUM_ROWS = 26;
    localparam row_t DIRECTED [NUM_ROWS] = '{
        '{fmbs_pkg::OP_QUERY, SYM_A, 17'd0, 17'd0, 1'b0, 1'b1, 17'd1, 17'd0, 17'd0, 1'b1},
        '{fmbs_pkg::OP_QUERY, SYM_T, 17'd0, 17'd0, 1'b1, 1'b1, 17'd1, 17'd0, 17'd0, 1'b1},
        '{OP_UNUSED, SYM_OTHER, CNT_MAX, CNT_MAX, 1'b1, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_START, SYM_A, 17'd5, 17'd3, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_QUERY, SYM_C, 17'd0, 17'd0, 1'b0, 1'b1, 17'd5, 17'd3, 17'd0, 1'b1},
        '{fmbs_pkg::OP_START, SYM_A, 17'd0, CNT_MAX, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_QUERY, SYM_OTHER, 17'd0, 17'd0, 1'b1, 1'b1, 17'd0, CNT_MAX, 17'd0,
          1'b1},
        '{fmbs_pkg::OP_LOAD, SYM_A, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_C, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_G, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_T, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_DOLLAR, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_OTHER, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_A, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_A, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_C, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_G, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_T, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_LOAD, SYM_T, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_START, SYM_A, 17'd0, CNT_MAX, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_QUERY, SYM_G, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_QUERY, SYM_A, 17'd0, 17'd0, 1'b1, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_START, SYM_A, 17'd0, 17'd0, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_QUERY, SYM_A, 17'd0, 17'd0, 1'b1, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_START, SYM_A, CNT_MAX, CNT_MAX, 1'b0, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0},
        '{fmbs_pkg::OP_QUERY, SYM_T, 17'd0, 17'd0, 1'b1, 1'b0, 17'd0, 17'd0, 17'd0, 1'b0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [fmbs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fmbs_pkg::CNT_W-1:0] cfg_data;

    fmbs_in_if in_ch ();
    fmbs_out_if out_ch ();

    fm_index_backward_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [fmbs_pkg::SYM_W-1:0] text_mem [fmbs_pkg::TEXT_DEPTH];
    int unsigned ckpt_mem [fmbs_pkg::NUM_BASES][fmbs_pkg::CKPT_DEPTH];
    bit ckpt_done [fmbs_pkg::CKPT_DEPTH];
    int unsigned base_tally [fmbs_pkg::NUM_BASES];
    int unsigned below [fmbs_pkg::NUM_BASES];
    int unsigned text_len;
    int unsigned cur_low;
    int unsigned cur_high;
    bit cur_dead;
    int unsigned ratio_reg;

    bounds_t pending_bounds [$];
    int mismatches;
    int items_sent;
    int loads_sent;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    bit hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned ratio_eff(int unsigned r);
        if (r < 16)
        begin
            return 16;
        end
        if (r > 256)
        begin
            return 256;
        end
        return r;
    endfunction

    function automatic int unsigned clip17(longint unsigned v);
        return (v > CNT_MAX) ? CNT_MAX : int'(v);
    endfunction

    function automatic int unsigned occ_count(int unsigned b, int unsigned loc);
        int unsigned r;
        int unsigned id;
        int unsigned n;
        int unsigned p;
        r = ratio_eff(ratio_reg);
        if (text_len == 0)
        begin
            return 0;
        end
        if (loc >= text_len)
        begin
            loc = text_len - 1;
        end
        id = loc / r;
        if (id >= fmbs_pkg::CKPT_DEPTH)
        begin
            id = fmbs_pkg::CKPT_DEPTH - 1;
        end
        n = ckpt_mem[b][id];
        for (p = id * r; p <= loc; p++)
        begin
            if (text_mem[p] == fmbs_pkg::SYM_W'(b))
            begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic bit ratio_safe(int unsigned r);
        int unsigned re;
        int unsigned id;
        re = ratio_eff(r);
        if (text_len == 0)
        begin
            return 1'b1;
        end
        for (id = 0; id <= (text_len - 1) / re && id < fmbs_pkg::CKPT_DEPTH; id++)
        begin
            if (!ckpt_done[id])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic predict_item(logic [fmbs_pkg::OP_W-1:0] op, logic [fmbs_pkg::SYM_W-1:0] sym,
                                fmbs_pkg::count_t lo, fmbs_pkg::count_t hi, logic last);
        int unsigned r;
        int unsigned ol;
        int unsigned oh;
        bounds_t res;
        r = ratio_eff(ratio_reg);
        if (op == fmbs_pkg::OP_LOAD)
        begin
            if (text_len < fmbs_pkg::TEXT_DEPTH)
            begin
                if (text_len % r == 0 && text_len / r < fmbs_pkg::CKPT_DEPTH)
                begin
                    for (int b = 0; b < fmbs_pkg::NUM_BASES; b++)
                    begin
                        ckpt_mem[b][text_len / r] = base_tally[b];
                    end
                    ckpt_done[text_len / r] = 1'b1;
                end
                text_mem[text_len] = sym;
                if (sym < 4)
                begin
                    base_tally[sym] = clip17(base_tally[sym] + 1);
                end
                text_len++;
            end
        end
        else if (op == fmbs_pkg::OP_START)
        begin
            cur_low = lo;
            cur_high = hi;
            cur_dead = lo > hi;
        end
        else if (op == fmbs_pkg::OP_QUERY)
        begin
            if (!cur_dead)
            begin
                if (sym > SYM_T)
                begin
                    cur_dead = 1'b1;
                end
                else
                begin
                    ol = (cur_low == 0) ? 0 : occ_count(sym, cur_low - 1);
                    oh = occ_count(sym, cur_high);
                    cur_low = clip17(longint'(below[sym]) + ol + 1);
                    cur_high = clip17(longint'(below[sym]) + oh);
                    cur_dead = cur_low > cur_high;
                end
            end
            res.lo = fmbs_pkg::count_t'(cur_low);
            res.hi = fmbs_pkg::count_t'(cur_high);
            res.empty = cur_dead || cur_low > cur_high;
            res.cnt = res.empty ? '0 : fmbs_pkg::count_t'(clip17(cur_high - cur_low + 1));
            res.last = last;
            pending_bounds.push_back(res);
        end
    endtask

    task automatic write_reg(logic [fmbs_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = fmbs_pkg::CNT_W'(value);
        if (idx == fmbs_pkg::REG_SAMPLE_RATIO)
        begin
            ratio_reg = value & 9'h1FF;
        end
        else
        begin
            below[idx - 1] = value & CNT_MAX;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_bounds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(logic [fmbs_pkg::OP_W-1:0] op, logic [fmbs_pkg::SYM_W-1:0] sym,
                             fmbs_pkg::count_t lo, fmbs_pkg::count_t hi, logic last,
                             bit use_pred);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.opcode = op;
        in_ch.symbol = sym;
        in_ch.start_low = lo;
        in_ch.start_high = hi;
        in_ch.last_base = last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        if (use_pred)
        begin
            predict_item(op, sym, lo, hi, last);
        end
        if (op != OP_UNUSED)
        begin
            items_sent++;
        end
        if (op == fmbs_pkg::OP_LOAD)
        begin
            loads_sent++;
        end
    endtask

    task automatic report(string what, bounds_t want, bounds_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch %s: expected lo=%0d hi=%0d cnt=%0d empty=%0b last=%0b",
                     what, want.lo, want.hi, want.cnt, want.empty, want.last);
            $display("    got lo=%0d hi=%0d cnt=%0d empty=%0b last=%0b",
                     got.lo, got.hi, got.cnt, got.empty, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        bounds_t got;
        bounds_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.lo = out_ch.low_bound;
            got.hi = out_ch.high_bound;
            got.cnt = out_ch.match_count;
            got.empty = out_ch.is_empty;
            got.last = out_ch.last;
            results_seen++;
            if (pending_bounds.size() == 0)
            begin
                want = '{default: '0};
                report("unexpected beat", want, got);
            end
            else
            begin
                want = pending_bounds.pop_front();
                if (got != want)
                begin
                    report("result", want, got);
                end
            end
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic random_search();
        int unsigned lo;
        int unsigned hi;
        int unsigned nq;
        logic [fmbs_pkg::SYM_W-1:0] sym;
        if ($urandom_range(99) < 60 && text_len > 0)
        begin
            lo = 0;
            hi = text_len - 1;
        end
        else
        begin
            lo = $urandom_range(text_len);
            hi = $urandom_range(lo, text_len + 2);
        end
        send_item(fmbs_pkg::OP_START, SYM_A, fmbs_pkg::count_t'(lo), fmbs_pkg::count_t'(hi),
                  1'b0, 1'b1);
        nq = $urandom_range(1, 8);
        for (int q = 0; q < nq; q++)
        begin
            sym = ($urandom_range(99) < 4) ? fmbs_pkg::SYM_W'($urandom_range(4, 7))
                                            : fmbs_pkg::SYM_W'($urandom_range(0, 3));
            send_item(fmbs_pkg::OP_QUERY, sym, fmbs_pkg::count_t'($urandom),
                      fmbs_pkg::count_t'($urandom),
                      (q == nq - 1) ? 1'b1 : 1'(($urandom_range(9) == 0)), 1'b1);
        end
    endtask

    task automatic random_noise();
        case ($urandom_range(3))
            0: send_item(OP_UNUSED, fmbs_pkg::SYM_W'($urandom), fmbs_pkg::count_t'($urandom),
                         fmbs_pkg::count_t'($urandom), 1'($urandom), 1'b1);
            1: send_item(fmbs_pkg::OP_START, fmbs_pkg::SYM_W'($urandom),
                         fmbs_pkg::count_t'($urandom), fmbs_pkg::count_t'($urandom),
                         1'($urandom), 1'b1);
            2: send_item(fmbs_pkg::OP_QUERY, fmbs_pkg::SYM_W'($urandom),
                         fmbs_pkg::count_t'($urandom), fmbs_pkg::count_t'($urandom),
                         1'($urandom), 1'b1);
            default: send_item(fmbs_pkg::OP_START, SYM_A,
                               fmbs_pkg::count_t'($urandom_range(40, 200)),
                               fmbs_pkg::count_t'($urandom_range(0, 39)), 1'b0, 1'b1);
        endcase
    endtask

    initial
    begin
        int unsigned phase_ratio [6];
        int unsigned acc;
        int phase_end;
        int unsigned nl;
        logic [fmbs_pkg::SYM_W-1:0] sym;
        phase_ratio = '{16, 511, 24, 256, 40, 17};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = fmbs_pkg::OP_LOAD;
        in_ch.symbol = '0;
        in_ch.start_low = '0;
        in_ch.start_high = '0;
        in_ch.last_base = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        mismatches = 0;
        items_sent = 0;
        loads_sent = 0;
        results_seen = 0;
        text_len = 0;
        cur_low = 0;
        cur_high = 0;
        cur_dead = 1'b0;
        ratio_reg = fmbs_pkg::RATIO_RESET;
        for (int b = 0; b < fmbs_pkg::NUM_BASES; b++)
        begin
            base_tally[b] = 0;
            below[b] = 0;
        end
        send_idle_pct = 37;
        recv_idle_pct = 48;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        write_reg(fmbs_pkg::REG_SAMPLE_RATIO, 0);
        write_reg(fmbs_pkg::REG_COUNT_A, 0);
        write_reg(fmbs_pkg::REG_COUNT_C, 5);
        write_reg(fmbs_pkg::REG_COUNT_G, 65536);
        write_reg(fmbs_pkg::REG_COUNT_T, CNT_MAX);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED[i].typed)
            begin
                send_item(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].lo, DIRECTED[i].hi,
                          DIRECTED[i].last, 1'b0);
                pending_bounds.push_back('{DIRECTED[i].e_lo, DIRECTED[i].e_hi,
                                           DIRECTED[i].e_cnt, DIRECTED[i].e_empty,
                                           DIRECTED[i].last});
                predict_item(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].lo,
                             DIRECTED[i].hi, DIRECTED[i].last);
                void'(pending_bounds.pop_back());
            end
            else
            begin
                send_item(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].lo, DIRECTED[i].hi,
                          DIRECTED[i].last, 1'b1);
            end
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            wait_idle();
            if (ph == 2)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 37;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph > 0)
            begin
                write_reg(fmbs_pkg::REG_SAMPLE_RATIO,
                          ratio_safe(phase_ratio[ph]) ? phase_ratio[ph] : ratio_reg);
            end
            if (ph % 2 == 0)
            begin
                acc = text_len - base_tally[0] - base_tally[1] - base_tally[2]
                      - base_tally[3];
                for (int b = 0; b < fmbs_pkg::NUM_BASES; b++)
                begin
                    write_reg(fmbs_pkg::CFG_IDX_W'(b + 1), acc);
                    acc += base_tally[b];
                end
            end
            else
            begin
                for (int b = 0; b < fmbs_pkg::NUM_BASES; b++)
                begin
                    write_reg(fmbs_pkg::CFG_IDX_W'(b + 1), $urandom_range(0, 65536));
                end
            end
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
            begin
                acc = $urandom_range(99);
                if (ph == 4 && !hold_done && items_sent > phase_end - ITEMS_PER_PHASE / 2)
                begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                if (acc < 25 || text_len < 20)
                begin
                    nl = $urandom_range(1, 20);
                    for (int k = 0; k < nl; k++)
                    begin
                        sym = ($urandom_range(99) < 10) ? fmbs_pkg::SYM_W'($urandom_range(4, 7))
                                                         : fmbs_pkg::SYM_W'($urandom_range(0, 3));
                        send_item(fmbs_pkg::OP_LOAD, sym, fmbs_pkg::count_t'($urandom),
                                  fmbs_pkg::count_t'($urandom), 1'($urandom), 1'b1);
                    end
                end
                else if (acc < 88)
                begin
                    random_search();
                end
                else
                begin
                    random_noise();
                end
            end
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        wait_idle();
        $display("run covered %0d items (%0d loads) over six register settings, %0d results",
                 items_sent, loads_sent, results_seen);
        $display("text length %0d symbols, %0d mismatches", text_len, mismatches);
        if (mismatches == 0 && pending_bounds.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
